// ===== rtl/core/cef_pkg.sv =====
package cef_pkg;

    localparam int TYPE_W    = 8;
    localparam int PAYLOAD_W = 32;
    localparam int SLOT_W    = TYPE_W + PAYLOAD_W;
    localparam int OCC_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    localparam logic [TYPE_W-1:0] TICK_TYPE_RESET = 8'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_TYPE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COALESCE  = 1'd1;

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [1:0] STS_DONE  = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

endpackage

// ===== rtl/core/cef_ram.sv =====
module cef_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/coalescing_event_fifo.sv =====
// Event queue of DEPTH slots in one synchronous RAM, holding up to DEPTH-1 events of an
// 8-bit type and a 32-bit payload. A push, a query or a pop on an empty queue loads the
// result register on acceptance. A returned event goes through ST_POP, since the oldest slot
// comes from the RAM read port in the cycle after acceptance; ST_POP holds off the input.
// A timer tick pushed while the newest queued event is also a tick (and coalescing is
// enabled) overwrites that event's payload instead of taking a slot; this also works on a
// full queue. A new item is accepted only while the result register is empty or its
// result is taken in the same cycle, so a result that waits on m_ready holds off the input.
// Occupancy is reported modulo 32. Write configuration only while no item is in flight.
module coalescing_event_fifo #(
    parameter int DEPTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_action,
    input  logic [cef_pkg::TYPE_W-1:0]          s_in_type,
    input  logic [cef_pkg::PAYLOAD_W-1:0]       s_in_payload,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic                                m_merged,
    output logic [cef_pkg::TYPE_W-1:0]          m_out_type,
    output logic [cef_pkg::PAYLOAD_W-1:0]       m_out_payload,
    output logic [cef_pkg::OCC_W-1:0]           m_occupancy,
    input  logic                                cfg_we,
    input  logic [cef_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cef_pkg::CFG_DAT_W-1:0]       cfg_wdata
);

    import cef_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    state_t state_reg, state_next;

    logic [AW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [TYPE_W-1:0]    newest_type_reg, newest_type_next;
    logic [TYPE_W-1:0]    tick_reg;
    logic                 coalesce_reg;

    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           status_reg, status_next;
    logic                 merged_reg, merged_next;
    logic [TYPE_W-1:0]    otype_reg, otype_next;
    logic [PAYLOAD_W-1:0] opay_reg, opay_next;
    logic [OCC_W-1:0]     occ_reg, occ_next;

    logic                 accept, out_free, load_now, load_pop;
    logic                 empty, full, merge_hit;
    logic                 do_push, do_pop;
    logic [AW-1:0]        wr_inc, rd_inc, newest;
    logic [AW:0]          fill_raw;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr;
    logic [SLOT_W-1:0]    ram_wdata, ram_rdata;

    always_comb begin
        out_free = !m_valid_reg || m_ready;
        s_ready  = (state_reg == ST_IDLE) && out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_action == ACT_POP) && !empty) begin
                    state_next = ST_POP;
                end
            end
            ST_POP:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign accept = s_valid && s_ready;
    assign empty  = (wr_ptr_reg == rd_ptr_reg);
    assign wr_inc = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_inc = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign newest = (wr_ptr_reg == '0) ? LAST : wr_ptr_reg - 1'b1;
    assign full   = (wr_inc == rd_ptr_reg);

    assign merge_hit = coalesce_reg && !empty && (s_in_type == tick_reg)
                       && (newest_type_reg == tick_reg);

    assign do_push  = accept && (s_action == ACT_PUSH);
    assign do_pop   = accept && (s_action == ACT_POP) && !empty;
    assign load_now = accept && !do_pop;
    assign load_pop = (state_reg == ST_POP);

    assign ram_we    = do_push && (merge_hit || !full);
    assign ram_waddr = merge_hit ? newest : wr_ptr_reg;
    assign ram_wdata = merge_hit ? {newest_type_reg, s_in_payload}
                                 : {s_in_type, s_in_payload};
    assign ram_re    = do_pop;

    cef_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(DEPTH)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rdata)
    );

    always_comb begin
        wr_ptr_next      = wr_ptr_reg;
        rd_ptr_next      = rd_ptr_reg;
        newest_type_next = newest_type_reg;
        if (do_push && !merge_hit && !full) begin
            wr_ptr_next      = wr_inc;
            newest_type_next = s_in_type;
        end
        if (do_pop) begin
            rd_ptr_next = rd_inc;
        end
    end

    always_comb begin
        if (wr_ptr_next >= rd_ptr_next) begin
            fill_raw = {1'b0, wr_ptr_next} - {1'b0, rd_ptr_next};
        end else begin
            fill_raw = {1'b0, wr_ptr_next} + (AW + 1)'(DEPTH) - {1'b0, rd_ptr_next};
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        merged_next  = merged_reg;
        otype_next   = otype_reg;
        opay_next    = opay_reg;
        occ_next     = occ_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_now) begin
            m_valid_next = 1'b1;
            status_next  = STS_DONE;
            merged_next  = 1'b0;
            otype_next   = '0;
            opay_next    = '0;
            occ_next     = OCC_W'(fill_raw);
            case (s_action)
                ACT_PUSH: begin
                    if (merge_hit) begin
                        merged_next = 1'b1;
                    end else if (full) begin
                        status_next = STS_FULL;
                    end
                end
                ACT_POP:   status_next = STS_EMPTY;
                ACT_QUERY: status_next = STS_DONE;
                default:   status_next = STS_DONE;
            endcase
        end else if (load_pop) begin
            m_valid_next = 1'b1;
            status_next  = STS_DONE;
            merged_next  = 1'b0;
            otype_next   = ram_rdata[SLOT_W-1:PAYLOAD_W];
            opay_next    = ram_rdata[PAYLOAD_W-1:0];
            occ_next     = OCC_W'(fill_raw);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            newest_type_reg <= '0;
            tick_reg        <= TICK_TYPE_RESET;
            coalesce_reg    <= 1'b1;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            newest_type_reg <= newest_type_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_TICK_TYPE: tick_reg     <= cfg_wdata;
                    CFG_COALESCE:  coalesce_reg <= cfg_wdata[0];
                    default:       tick_reg     <= tick_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        merged_reg <= merged_next;
        otype_reg  <= otype_next;
        opay_reg   <= opay_next;
        occ_reg    <= occ_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_merged      = merged_reg;
    assign m_out_type    = otype_reg;
    assign m_out_payload = opay_reg;
    assign m_occupancy   = occ_reg;

endmodule

// ===== rtl/core/cef_checker.sv =====
module cef_checker #(
    parameter int DEPTH = 32
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [1:0]                    m_status,
    input logic                          m_merged,
    input logic [cef_pkg::TYPE_W-1:0]    m_out_type,
    input logic [cef_pkg::PAYLOAD_W-1:0] m_out_payload,
    input logic [cef_pkg::OCC_W-1:0]     m_occupancy
);

    import cef_pkg::*;

    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH - 1);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_payload)
            && $stable(m_occupancy))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STS_EMPTY) |->
            (m_out_type == '0) && (m_out_payload == '0) && !m_merged
            && (m_occupancy == '0))
        else $error("failed pop carries data");

    a_merge_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_merged |-> (m_status == STS_DONE) && (m_out_payload == '0))
        else $error("merged item with bad status");

    a_full_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STS_FULL) |-> (m_occupancy == FULL_OCC) && !m_merged)
        else $error("rejected push with wrong occupancy");

endmodule

bind coalescing_event_fifo cef_checker #(.DEPTH(DEPTH)) u_cef_checker (.*);

// ===== tb/coalescing_event_fifo_test.sv =====
module coalescing_event_fifo_test;
    import cef_pkg::*;

    localparam int DEPTH = 32;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 200;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]           status;
        logic                 merged;
        logic [TYPE_W-1:0]    ev_type;
        logic [PAYLOAD_W-1:0] ev_pay;
        logic [OCC_W-1:0]     occ;
    } outcome_t;

    typedef struct packed {
        logic [1:0]           act;
        logic [TYPE_W-1:0]    typ;
        logic [PAYLOAD_W-1:0] pay;
        int                   reps;
        logic                 typed;
        outcome_t             want;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_action = ACT_QUERY;
    logic [TYPE_W-1:0]    s_in_type = '0;
    logic [PAYLOAD_W-1:0] s_in_payload = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [1:0]           m_status;
    logic                 m_merged;
    logic [TYPE_W-1:0]    m_out_type;
    logic [PAYLOAD_W-1:0] m_out_payload;
    logic [OCC_W-1:0]     m_occupancy;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_TICK_TYPE;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;

    logic [TYPE_W-1:0]    ring_type [DEPTH];
    logic [PAYLOAD_W-1:0] ring_pay [DEPTH];
    int                   wr_idx = 0;
    int                   rd_idx = 0;
    logic [TYPE_W-1:0]    tick_code = TICK_TYPE_RESET;
    logic                 merge_on = 1'b1;

    outcome_t pending_outcomes [$];
    int       mismatches = 0;
    bit       send_idle = 1'b1;
    bit       recv_idle = 1'b1;
    int       push_pct = 50;
    dir_row_t dir_plan [20];

    coalescing_event_fifo #(.DEPTH(DEPTH)) uut (.*);

    initial forever #10 aclk = ~aclk;

    initial begin
        #(20 * 400000);
        $display("coalescing_event_fifo_test: FAIL");
        $finish;
    end

    function automatic outcome_t fifo_predict(input logic [1:0] act,
                                              input logic [TYPE_W-1:0] typ,
                                              input logic [PAYLOAD_W-1:0] pay);
        outcome_t r;
        int newest;
        bit empty;
        r = '0;
        empty = (wr_idx == rd_idx);
        newest = (wr_idx + DEPTH - 1) % DEPTH;
        if (act == ACT_PUSH) begin
            if (merge_on && !empty && typ == tick_code && ring_type[newest] == tick_code) begin
                ring_pay[newest] = pay;
                r.merged = 1'b1;
            end else if ((wr_idx + 1) % DEPTH == rd_idx) begin
                r.status = STS_FULL;
            end else begin
                ring_type[wr_idx] = typ;
                ring_pay[wr_idx] = pay;
                wr_idx = (wr_idx + 1) % DEPTH;
            end
        end else if (act == ACT_POP) begin
            if (empty) begin
                r.status = STS_EMPTY;
            end else begin
                r.ev_type = ring_type[rd_idx];
                r.ev_pay = ring_pay[rd_idx];
                rd_idx = (rd_idx + 1) % DEPTH;
            end
        end
        r.occ = OCC_W'((wr_idx + DEPTH - rd_idx) % DEPTH);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic int draw_wait(input bit idle);
        if (!idle) return 0;
        return $urandom_range(0, 13);
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [TYPE_W-1:0] typ,
                             input logic [PAYLOAD_W-1:0] pay, input logic typed,
                             input outcome_t want);
        int gap;
        outcome_t predicted;
        gap = draw_wait(send_idle);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_in_type <= typ;
        s_in_payload <= pay;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = fifo_predict(act, typ, pay);
        pending_outcomes.push_back(typed ? want : predicted);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic configure(input logic [TYPE_W-1:0] code, input logic enable);
        cfg_we <= 1'b1;
        cfg_index <= CFG_TICK_TYPE;
        cfg_wdata <= code;
        @(negedge aclk);
        cfg_index <= CFG_COALESCE;
        cfg_wdata <= {7'($urandom), enable};
        @(negedge aclk);
        cfg_we <= 1'b0;
        tick_code = code;
        merge_on = enable;
        @(negedge aclk);
    endtask

    task automatic collect_results();
        int stall;
        outcome_t want;
        forever begin
            stall = draw_wait(recv_idle);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected item, status", 32'(m_status), '0);
            end else begin
                want = pending_outcomes.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", 32'(m_status), 32'(want.status));
                if (m_merged !== want.merged)
                    report_mismatch("merged", 32'(m_merged), 32'(want.merged));
                if (m_out_type !== want.ev_type)
                    report_mismatch("out_type", 32'(m_out_type), 32'(want.ev_type));
                if (m_out_payload !== want.ev_pay)
                    report_mismatch("out_payload", m_out_payload, want.ev_pay);
                if (m_occupancy !== want.occ)
                    report_mismatch("occupancy", 32'(m_occupancy), 32'(want.occ));
            end
            @(negedge aclk);
        end
    endtask

    function automatic logic [1:0] pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return ACT_SPARE;
        if (r < 10) return ACT_QUERY;
        if ($urandom_range(0, 99) < push_pct) return ACT_PUSH;
        return ACT_POP;
    endfunction

    function automatic logic [TYPE_W-1:0] pick_type();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return tick_code;
        if (r < 50) return tick_code ^ 8'h01;
        return TYPE_W'($urandom);
    endfunction

    function automatic logic [PAYLOAD_W-1:0] pick_payload();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        return $urandom;
    endfunction

    initial begin
        logic [TYPE_W-1:0] codes [PHASES];
        logic              enables [PHASES];
        dir_plan = '{
            '{ACT_QUERY, 8'h00, 32'h0, 1, 1'b1, '{STS_DONE, 1'b0, 8'h00, 32'h0, 5'd0}},
            '{ACT_POP, 8'h00, 32'h0, 1, 1'b1, '{STS_EMPTY, 1'b0, 8'h00, 32'h0, 5'd0}},
            '{ACT_SPARE, 8'hFF, 32'hFFFFFFFF, 1, 1'b1,
              '{STS_DONE, 1'b0, 8'h00, 32'h0, 5'd0}},
            '{ACT_PUSH, 8'hFF, 32'hFFFFFFFF, 1, 1'b1,
              '{STS_DONE, 1'b0, 8'h00, 32'h0, 5'd1}},
            '{ACT_PUSH, 8'h02, 32'h0, 1, 1'b1, '{STS_DONE, 1'b0, 8'h00, 32'h0, 5'd2}},
            '{ACT_PUSH, 8'h02, 32'hA5A5A5A5, 1, 1'b1,
              '{STS_DONE, 1'b1, 8'h00, 32'h0, 5'd2}},
            '{ACT_QUERY, 8'h00, 32'h0, 1, 1'b1, '{STS_DONE, 1'b0, 8'h00, 32'h0, 5'd2}},
            '{ACT_POP, 8'h00, 32'h0, 1, 1'b1,
              '{STS_DONE, 1'b0, 8'hFF, 32'hFFFFFFFF, 5'd1}},
            '{ACT_POP, 8'h00, 32'h0, 1, 1'b1,
              '{STS_DONE, 1'b0, 8'h02, 32'hA5A5A5A5, 5'd0}},
            '{ACT_POP, 8'h00, 32'h0, 1, 1'b1, '{STS_EMPTY, 1'b0, 8'h00, 32'h0, 5'd0}},
            '{ACT_PUSH, 8'h02, 32'h1, 1, 1'b0, '0},
            '{ACT_PUSH, 8'h00, 32'h0, 1, 1'b0, '0},
            '{ACT_PUSH, 8'h02, 32'h5A5A5A5A, 1, 1'b0, '0},
            '{ACT_PUSH, 8'h80, 32'h80000000, 27, 1'b0, '0},
            '{ACT_PUSH, 8'h02, 32'h12345678, 1, 1'b0, '0},
            '{ACT_PUSH, 8'h01, 32'hDEADBEEF, 1, 1'b1,
              '{STS_FULL, 1'b0, 8'h00, 32'h0, 5'd31}},
            '{ACT_PUSH, 8'h02, 32'hFFFFFFFF, 1, 1'b1,
              '{STS_DONE, 1'b1, 8'h00, 32'h0, 5'd31}},
            '{ACT_QUERY, 8'h00, 32'h0, 1, 1'b1, '{STS_DONE, 1'b0, 8'h00, 32'h0, 5'd31}},
            '{ACT_POP, 8'h00, 32'h0, 31, 1'b0, '0},
            '{ACT_POP, 8'h00, 32'h0, 1, 1'b1, '{STS_EMPTY, 1'b0, 8'h00, 32'h0, 5'd0}}
        };
        codes = '{8'h00, 8'hFF, 8'h02, 8'($urandom), 8'hFF, 8'h00, 8'($urandom), 8'h02};
        enables = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'($urandom), 1'b1};

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        fork
            collect_results();
        join_none

        foreach (dir_plan[i]) begin
            for (int k = 0; k < dir_plan[i].reps; k++) begin
                send_item(dir_plan[i].act, dir_plan[i].typ, dir_plan[i].pay + k,
                          dir_plan[i].typed, dir_plan[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            configure(codes[p], enables[p]);
            send_idle = (p % 4 == 0) || (p % 4 == 1);
            recv_idle = (p % 4 == 0) || (p % 4 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) push_pct = (n % 80 == 0) ? 80 : $urandom_range(20, 60);
                if (n == PHASE_ITEMS / 2 || $urandom_range(0, 99) == 0) drain_results();
                send_item(pick_action(), pick_type(), pick_payload(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (20) @(negedge aclk);
        if (mismatches == 0) begin
            $display("coalescing_event_fifo_test: PASS");
        end else begin
            $display("coalescing_event_fifo_test: FAIL");
        end
        $finish;
    end

endmodule

// ===== coalescing_event_fifo.f =====
rtl/core/cef_pkg.sv
rtl/core/cef_ram.sv
rtl/core/coalescing_event_fifo.sv
rtl/core/cef_checker.sv
tb/coalescing_event_fifo_test.sv
